// ===== design/rbm_pkg.sv =====
// Shared types and constants for the RGB blend mode mixer.
// Holds pixel structs, blend mode codes, register indexes and lane settings.
// No dependencies; every other design file imports it.
`default_nettype none

package rbm_pkg;

  localparam int unsigned CHAN_W      = 8;
  localparam int unsigned OPACITY_W   = 9;
  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 9;

  localparam logic [CHAN_W-1:0]    CH_MAX        = 8'd255;
  localparam logic [CHAN_W-1:0]    OVERLAY_SPLIT = 8'd128;
  localparam logic [OPACITY_W-1:0] FULL_OPACITY  = 9'd256;

  // Register indexes on the configuration port
  localparam logic [CFG_INDEX_W-1:0] CFG_MIX_MODE   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_OPACITY    = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_BASE_RED   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_BASE_GREEN = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_BASE_BLUE  = 3'd4;

  typedef enum logic [1:0] {
    MODE_NORMAL   = 2'd0,
    MODE_MULTIPLY = 2'd1,
    MODE_OVERLAY  = 2'd2,
    MODE_SCREEN   = 2'd3
  } mix_mode_t;

  typedef struct packed {
    logic [CHAN_W-1:0] tex_red;
    logic [CHAN_W-1:0] tex_green;
    logic [CHAN_W-1:0] tex_blue;
  } tex_pixel_t;

  typedef struct packed {
    logic [CHAN_W-1:0] out_red;
    logic [CHAN_W-1:0] out_green;
    logic [CHAN_W-1:0] out_blue;
  } out_pixel_t;

  // Settings shared by all three lanes; opacity is already saturated
  typedef struct packed {
    mix_mode_t             mode;
    logic [OPACITY_W-1:0]  opacity;
  } lane_cfg_t;

endpackage

`default_nettype wire

// ===== design/rbm_lane.sv =====
// One color channel of the blend mixer: blend product, divide by 255, opacity mix.
// Three register stages, advancing every cycle. Depends on rbm_pkg.
`default_nettype none

module rbm_lane (
  input  wire logic                    clk,
  input  wire rbm_pkg::lane_cfg_t      cfg,
  input  wire logic [7:0]              base,
  input  wire logic [7:0]              texel,
  output logic [7:0]                   mixed
);
  import rbm_pkg::*;

  // Stage 1 signals
  logic              invert;
  logic              dbl;
  logic              pass;
  logic [7:0]        mul_x;
  logic [7:0]        mul_y;
  logic [15:0]       prod;
  logic [16:0]       num_next;
  logic [16:0]       num;
  logic              comp;
  logic              bypass;
  logic [7:0]        tex1;
  logic [7:0]        base1;

  // Stage 2 signals
  logic [25:0]       recip;
  logic [9:0]        est;
  logic [17:0]       back;
  logic [17:0]       rem;
  logic [9:0]        quot;
  logic [7:0]        q8;
  logic [7:0]        blend_next;
  logic [7:0]        blend;
  logic [7:0]        base2;

  // Stage 3 signals
  logic signed [8:0]  diff;
  logic signed [9:0]  weight;
  logic signed [18:0] scaled;
  logic signed [19:0] total;

  // Pick operands: screen and the upper overlay half work on complements
  always_comb begin
    invert = 1'b0;
    dbl    = 1'b0;
    pass   = 1'b0;
    case (cfg.mode)
      MODE_NORMAL: begin
        pass = 1'b1;
      end
      MODE_MULTIPLY: begin
        invert = 1'b0;
      end
      MODE_OVERLAY: begin
        dbl    = 1'b1;
        invert = (base >= OVERLAY_SPLIT);
      end
      MODE_SCREEN: begin
        invert = 1'b1;
      end
      default: begin
        pass = 1'b1;
      end
    endcase
  end

  assign mul_x    = invert ? (CH_MAX - base)  : base;
  assign mul_y    = invert ? (CH_MAX - texel) : texel;
  assign prod     = 16'(mul_x) * 16'(mul_y);
  assign num_next = dbl ? {prod, 1'b0} : {1'b0, prod};

  always_ff @(posedge clk) begin
    num    <= num_next;
    comp   <= invert;
    bypass <= pass;
    tex1   <= texel;
    base1  <= base;
  end

  // Divide by 255: estimate n*257 >> 16 (never high), then one correction step
  assign recip = {9'd0, num} + {1'b0, num, 8'd0};
  assign est   = recip[25:16];
  assign back  = {est, 8'd0} - {8'd0, est};
  assign rem   = {1'b0, num} - back;
  assign quot  = (rem >= 18'(CH_MAX)) ? (est + 10'd1) : est;
  assign q8    = quot[7:0];

  assign blend_next = bypass ? tex1 : (comp ? (CH_MAX - q8) : q8);

  always_ff @(posedge clk) begin
    blend <= blend_next;
    base2 <= base1;
  end

  // Mix with base: (a*256 + (m - a)*p) >> 8, never negative
  assign diff   = signed'({1'b0, blend}) - signed'({1'b0, base2});
  assign weight = signed'({1'b0, cfg.opacity});
  assign scaled = diff * weight;
  assign total  = signed'({4'd0, base2, 8'd0}) + {scaled[18], scaled};

  always_ff @(posedge clk) begin
    mixed <= total[15:8];
  end

endmodule

`default_nettype wire

// ===== design/rbm_merge.sv =====
// Merge stage: packs the three lane results into one pixel and buffers them.
// Small register queue drives the result channel. Depends on rbm_pkg.
`default_nettype none

module rbm_merge #(
  parameter int unsigned OUT_DEPTH = 8
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           push,
  input  wire logic [7:0]                     red,
  input  wire logic [7:0]                     green,
  input  wire logic [7:0]                     blue,
  output logic                                blend_valid,
  input  wire logic                           blend_ready,
  output rbm_pkg::out_pixel_t                 blend,
  output logic [$clog2(OUT_DEPTH+1)-1:0]      fill
);
  import rbm_pkg::*;

  localparam int unsigned PTR_W  = $clog2(OUT_DEPTH);
  localparam int unsigned FILL_W = $clog2(OUT_DEPTH + 1);
  localparam logic [PTR_W-1:0]  LAST_PTR  = PTR_W'(OUT_DEPTH - 1);
  localparam logic [FILL_W-1:0] FULL_FILL = FILL_W'(OUT_DEPTH);

  out_pixel_t        slots [OUT_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic              pop;
  out_pixel_t        packed_pix;

  assign pop         = blend_valid && blend_ready;
  assign blend_valid = (fill != '0);
  assign blend       = slots[rd_ptr];

  // Combine the lanes into one pixel
  assign packed_pix.out_red   = red;
  assign packed_pix.out_green = green;
  assign packed_pix.out_blue  = blue;

  // Store incoming pixel
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= packed_pix;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : (wr_ptr + PTR_W'(1));
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : (rd_ptr + PTR_W'(1));
      end
      if (push && !pop) begin
        fill <= fill + FILL_W'(1);
      end else if (pop && !push) begin
        fill <= fill - FILL_W'(1);
      end
    end
  end

  // Upstream credit must keep pushes out of a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (fill == FULL_FILL) |-> (!push || pop))
    else $error("result queue overflow");

  a_fill_drop: assert property (@(posedge clk) disable iff (rst)
    (pop && !push) |=> (fill == $past(fill) - FILL_W'(1)))
    else $error("fill level did not drop after transfer");

endmodule

`default_nettype wire

// ===== design/rgb_blend_mode_mixer.sv =====
// Path: a pixel accepted on the input is loaded into the first of the three lane
// stages, moves through the other two lane stages, then enters the result queue
// and is offered on the result channel from there.
// Throughput: one pixel per clock while results are taken; the OUT_DEPTH-entry
// result queue grants input credit; a depth of five or more keeps the stream at full rate.
// Reset: blend mode normal, opacity 256, base color black; pipeline and queue empty.
`default_nettype none

module rgb_blend_mode_mixer #(
  parameter int unsigned OUT_DEPTH = 8
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 tex_valid,
  output logic                                      tex_ready,
  input  wire rbm_pkg::tex_pixel_t                  tex,
  output logic                                      blend_valid,
  input  wire logic                                 blend_ready,
  output rbm_pkg::out_pixel_t                       blend,
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [rbm_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  wire logic [rbm_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import rbm_pkg::*;

  localparam int unsigned STAGES = 3;
  localparam int unsigned FILL_W = $clog2(OUT_DEPTH + 1);
  localparam int unsigned CRED_W = FILL_W + 1;

  mix_mode_t             mix_mode;
  logic [OPACITY_W-1:0]  opacity;
  logic [CHAN_W-1:0]     base_red;
  logic [CHAN_W-1:0]     base_green;
  logic [CHAN_W-1:0]     base_blue;
  logic [OPACITY_W-1:0]  opacity_sat;

  lane_cfg_t             lane_cfg;
  logic [STAGES-1:0]     stg_valid;
  logic [FILL_W-1:0]     fill;
  logic [CRED_W-1:0]     in_flight;
  logic [CRED_W-1:0]     used;
  logic                  tex_xfer;
  logic [CHAN_W-1:0]     mix_red;
  logic [CHAN_W-1:0]     mix_green;
  logic [CHAN_W-1:0]     mix_blue;

  // Hold off register writes during reset
  assign cfg_ready = !rst;

  // Clamp opacity writes above full scale
  assign opacity_sat = (cfg_data[8] && (cfg_data[7:0] != 8'd0)) ? FULL_OPACITY
                                                               : cfg_data[8:0];

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      mix_mode   <= MODE_NORMAL;
      opacity    <= FULL_OPACITY;
      base_red   <= '0;
      base_green <= '0;
      base_blue  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MIX_MODE:   mix_mode   <= mix_mode_t'(cfg_data[1:0]);
        CFG_OPACITY:    opacity    <= opacity_sat;
        CFG_BASE_RED:   base_red   <= cfg_data[7:0];
        CFG_BASE_GREEN: base_green <= cfg_data[7:0];
        CFG_BASE_BLUE:  base_blue  <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  assign lane_cfg.mode    = mix_mode;
  assign lane_cfg.opacity = opacity;

  // Accept only out of reset and while the result queue has room for everything in flight
  assign in_flight = CRED_W'($countones(stg_valid));
  assign used      = in_flight + CRED_W'(fill);
  assign tex_ready = !rst && (used < CRED_W'(OUT_DEPTH));
  assign tex_xfer  = tex_valid && tex_ready;

  // Track pixels through the lane stages
  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= '0;
    end else begin
      stg_valid <= {stg_valid[STAGES-2:0], tex_xfer};
    end
  end

  rbm_lane u_lane_red (
    .clk   (clk),
    .cfg   (lane_cfg),
    .base  (base_red),
    .texel (tex.tex_red),
    .mixed (mix_red)
  );

  rbm_lane u_lane_green (
    .clk   (clk),
    .cfg   (lane_cfg),
    .base  (base_green),
    .texel (tex.tex_green),
    .mixed (mix_green)
  );

  rbm_lane u_lane_blue (
    .clk   (clk),
    .cfg   (lane_cfg),
    .base  (base_blue),
    .texel (tex.tex_blue),
    .mixed (mix_blue)
  );

  rbm_merge #(
    .OUT_DEPTH (OUT_DEPTH)
  ) u_merge (
    .clk         (clk),
    .rst         (rst),
    .push        (stg_valid[STAGES-1]),
    .red         (mix_red),
    .green       (mix_green),
    .blue        (mix_blue),
    .blend_valid (blend_valid),
    .blend_ready (blend_ready),
    .blend       (blend),
    .fill        (fill)
  );

  // Credit never promises more than the queue holds
  a_credit_bound: assert property (@(posedge clk) disable iff (rst)
    used <= CRED_W'(OUT_DEPTH))
    else $error("pixels in flight exceed result queue");

  a_opacity_range: assert property (@(posedge clk) disable iff (rst)
    opacity <= FULL_OPACITY)
    else $error("opacity register above full scale");

  a_enter_pipe: assert property (@(posedge clk) disable iff (rst)
    tex_xfer |=> stg_valid[0])
    else $error("accepted pixel missing from first stage");

endmodule

`default_nettype wire
